/* hdl/gbkv_pkg.sv */
`default_nettype none

package gbkv_pkg;

  // Width of the reported length field
  localparam int unsigned LenW = 24;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_FOUR_BYTE = 2'd2,
    ST_NUL       = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    PH_LEAD   = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2,
    PH_FOURTH = 2'd3
  } phase_e;

  // Byte class bounds
  localparam logic [7:0] DigitLo = 8'h30;
  localparam logic [7:0] DigitHi = 8'h39;
  localparam logic [7:0] TrailLo = 8'h40;
  localparam logic [7:0] TrailHi = 8'h7e;
  localparam logic [7:0] HighLo  = 8'h80;
  localparam logic [7:0] ExtLo   = 8'h81;
  localparam logic [7:0] HighHi  = 8'hfe;

  typedef struct packed {
    logic [LenW-1:0] length;
    status_e         status;
  } result_t;

endpackage

`default_nettype wire

/* hdl/gbkv_char_fsm.sv */
`default_nettype none

module gbkv_char_fsm #(
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                step_i,
  input  wire logic [7:0]          data_byte_i,
  input  wire logic                end_of_string_i,
  input  wire logic                stop_at_nul_i,
  output gbkv_pkg::result_t        result_o
);

  localparam int unsigned ExtW =
    (COUNT_WIDTH > gbkv_pkg::LenW) ? COUNT_WIDTH : gbkv_pkg::LenW;

  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
  logic [COUNT_WIDTH-1:0] start_q, start_d;
  gbkv_pkg::phase_e       phase_q, phase_d;
  gbkv_pkg::status_e      stop_q, stop_d;
  logic                   ext_q, ext_d;   // lead byte >= 0x81

  logic                   is_digit, is_trail, is_high;
  gbkv_pkg::status_e      fin_status;
  logic [COUNT_WIDTH-1:0] len_cnt;
  logic [ExtW-1:0]        len_ext;

  assign is_digit = (data_byte_i >= gbkv_pkg::DigitLo) && (data_byte_i <= gbkv_pkg::DigitHi);
  assign is_trail = (data_byte_i >= gbkv_pkg::TrailLo) && (data_byte_i <= gbkv_pkg::TrailHi);
  assign is_high  = (data_byte_i >= gbkv_pkg::ExtLo) && (data_byte_i <= gbkv_pkg::HighHi);

  assign cnt_d = (cnt_q == {COUNT_WIDTH{1'b1}}) ? cnt_q : cnt_q + COUNT_WIDTH'(1);

  // next state
  always_comb begin
    phase_d = phase_q;
    stop_d  = stop_q;
    start_d = start_q;
    ext_d   = ext_q;
    if (stop_q == gbkv_pkg::ST_OK) begin
      case (phase_q)
        gbkv_pkg::PH_LEAD: begin
          start_d = cnt_q;
          if (!data_byte_i[7]) begin
            if ((data_byte_i == 8'h00) && stop_at_nul_i) begin
              stop_d = gbkv_pkg::ST_NUL;
            end
          end else if (data_byte_i == 8'hff) begin
            stop_d = gbkv_pkg::ST_INVALID;
          end else begin
            ext_d   = (data_byte_i != gbkv_pkg::HighLo);
            phase_d = gbkv_pkg::PH_SECOND;
          end
        end
        gbkv_pkg::PH_SECOND: begin
          if (is_digit) begin
            if (ext_q) begin
              phase_d = gbkv_pkg::PH_THIRD;
            end else begin
              stop_d = gbkv_pkg::ST_INVALID;
            end
          end else if (is_trail || is_high || (data_byte_i == gbkv_pkg::HighLo)) begin
            phase_d = gbkv_pkg::PH_LEAD;
          end else begin
            stop_d = gbkv_pkg::ST_INVALID;
          end
        end
        gbkv_pkg::PH_THIRD: begin
          if (is_high) begin
            phase_d = gbkv_pkg::PH_FOURTH;
          end else begin
            stop_d = gbkv_pkg::ST_INVALID;
          end
        end
        gbkv_pkg::PH_FOURTH: begin
          stop_d = is_digit ? gbkv_pkg::ST_FOUR_BYTE : gbkv_pkg::ST_INVALID;
        end
        default: begin
          stop_d = gbkv_pkg::ST_INVALID;
        end
      endcase
    end
  end

  // result for a final byte; truncated character reads as invalid
  always_comb begin
    fin_status = stop_d;
    if ((stop_d == gbkv_pkg::ST_OK) && (phase_d != gbkv_pkg::PH_LEAD)) begin
      fin_status = gbkv_pkg::ST_INVALID;
    end
    len_cnt  = (fin_status != gbkv_pkg::ST_OK) ? start_d : cnt_d;
    len_ext  = ExtW'(len_cnt);
    result_o = '{length: len_ext[gbkv_pkg::LenW-1:0], status: fin_status};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      start_q <= '0;
      phase_q <= gbkv_pkg::PH_LEAD;
      stop_q  <= gbkv_pkg::ST_OK;
      ext_q   <= 1'b0;
    end else if (step_i) begin
      if (end_of_string_i) begin
        cnt_q   <= '0;
        start_q <= '0;
        phase_q <= gbkv_pkg::PH_LEAD;
        stop_q  <= gbkv_pkg::ST_OK;
        ext_q   <= 1'b0;
      end else begin
        cnt_q   <= cnt_d;
        start_q <= start_d;
        phase_q <= phase_d;
        stop_q  <= stop_d;
        ext_q   <= ext_d;
      end
    end
  end

  a_eos_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && end_of_string_i |=>
      (phase_q == gbkv_pkg::PH_LEAD) && (stop_q == gbkv_pkg::ST_OK) && (cnt_q == '0))
    else $error("string state not cleared after final byte");

  a_stop_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !end_of_string_i && (stop_q != gbkv_pkg::ST_OK) |=> $stable(stop_q))
    else $error("stop code changed mid-string");

  a_stop_freezes_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !end_of_string_i && (stop_q != gbkv_pkg::ST_OK) |=>
      $stable(phase_q) && $stable(start_q))
    else $error("character state moved after a stop");

endmodule

`default_nettype wire

/* hdl/gb18030_gbk_stream_validator_unit.sv */
// GB18030 / GBK stream validator.
//
// Input channel (in_valid_i / in_ready_o): one string byte per word, with
// end_of_string_i high on the last byte. Multi-byte structure is checked per
// character (ASCII, two-byte, four-byte); checking stops at the first invalid
// or four-byte character, or at a NUL lead byte while stop_at_nul is set.
// Output channel (out_valid_o / out_ready_i): one word per string, on its
// last byte: accepted_length_o and status_o (0 ok, 1 invalid, 2 four-byte,
// 3 NUL). Other bytes produce no output word.
// Config: cfg_we_i writes cfg_wdata_i into stop_at_nul (reset value 1);
// write only while the block is idle.
// Throughput: one byte per clock while no final byte waits on a held result
// register. A final byte passes the input register, then loads the result
// register, which raises out_valid_o.
// Stalls: while the result register is held by out_ready_i low, non-final
// bytes keep flowing; a final byte waits in the input register, and
// in_ready_o drops until the result is taken.
// Reset (rst_ni, async, active low) clears both registers' valid flags and
// the per-string state, and sets stop_at_nul.
`default_nettype none

module gb18030_gbk_stream_validator_unit #(
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic                        cfg_wdata_i,
  input  wire logic                        in_valid_i,
  output      logic                        in_ready_o,
  input  wire logic [7:0]                  data_byte_i,
  input  wire logic                        end_of_string_i,
  output      logic                        out_valid_o,
  input  wire logic                        out_ready_i,
  output      logic [gbkv_pkg::LenW-1:0]   accepted_length_o,
  output      logic [1:0]                  status_o
);

  logic              stop_at_nul_q;

  // input register
  logic              in_valid_q;
  logic [7:0]        data_q;
  logic              eos_q;

  // result register
  logic              out_valid_q;
  gbkv_pkg::result_t res_q;
  gbkv_pkg::result_t res_d;

  logic              out_free;
  logic              consume;

  assign out_free   = !out_valid_q || out_ready_i;
  // a final byte needs a free result slot; other bytes go straight through
  assign consume    = in_valid_q && (!eos_q || out_free);
  assign in_ready_o = !in_valid_q || consume;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_at_nul_q <= 1'b1;
    end else if (cfg_we_i) begin
      stop_at_nul_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_byte_i;
      eos_q  <= end_of_string_i;
    end
  end

  gbkv_char_fsm #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_char_fsm (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (consume),
    .data_byte_i    (data_q),
    .end_of_string_i(eos_q),
    .stop_at_nul_i  (stop_at_nul_q),
    .result_o       (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (consume && eos_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume && eos_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign accepted_length_o = res_q.length;
  assign status_o          = res_q.status;

  a_final_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    consume && eos_q |=> out_valid_q)
    else $error("final byte consumed without a result word");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !(consume && eos_q))
    else $error("pending result overwritten");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !in_ready_o |=> in_valid_q && $stable(data_q) && $stable(eos_q))
    else $error("input register lost a stalled word");

  a_stall_only_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_valid_q && eos_q && out_valid_q)
    else $error("input stalled without a pending result");

endmodule

`default_nettype wire

/* sim/gb18030_gbk_stream_validator_unit_tb.sv */
`default_nettype none

module gb18030_gbk_stream_validator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CountW    = 24;
  localparam int unsigned RunLimit  = 200000;  // cycles, many times the slowest clean run
  localparam int unsigned SettleCyc = 4;       // input reg + result reg, with margin
  localparam int unsigned DrainCyc  = 16;
  localparam int unsigned LongHold  = 300;     // receiver back-pressure stretch
  localparam logic [7:0]  BadLead   = 8'hff;   // never a legal lead byte
  localparam logic [7:0]  NulByte   = 8'h00;

  // directed stimulus: byte, last-byte flag, and a typed verdict where it is obvious
  typedef struct packed {
    logic [7:0]                data;
    logic                      last;
    logic                      fixed;
    logic [gbkv_pkg::LenW-1:0] len;
    gbkv_pkg::status_e         st;
  } dir_row_t;

  localparam int DirRows = 24;

  // DUT ports
  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_we_i = 1'b0;
  logic            cfg_wdata_i = 1'b0;
  logic            in_valid_i = 1'b0;
  logic            in_ready_o;
  logic [7:0]      data_byte_i = 8'h00;
  logic            end_of_string_i = 1'b0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  logic [gbkv_pkg::LenW-1:0] accepted_length_o;
  logic [1:0]      status_o;

  // validator shadow state, mirrors the block per string
  logic              nul_stop;
  logic [CountW-1:0] seen_bytes;
  logic [CountW-1:0] char_origin;
  gbkv_pkg::phase_e  char_pos;
  logic [7:0]        char_lead;
  gbkv_pkg::status_e halt_code;   // ST_OK while still validating

  gbkv_pkg::result_t expected_verdicts[$];
  gbkv_pkg::result_t verdict_head;
  logic [7:0]        string_bytes[$];
  dir_row_t          dir_rows[DirRows];

  int unsigned     error_count = 0;
  int unsigned     cycle_count = 0;
  int unsigned     bytes_sent = 0;
  int unsigned     verdicts_seen = 0;
  int unsigned     status_tally[4] = '{0, 0, 0, 0};
  int unsigned     burst_left = 0;
  bit              hold_req = 1'b0;

  gb18030_gbk_stream_validator_unit #(
    .COUNT_WIDTH(CountW)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .data_byte_i      (data_byte_i),
    .end_of_string_i  (end_of_string_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .accepted_length_o(accepted_length_o),
    .status_o         (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RunLimit) begin
      $display("%0t: timeout, %0d verdicts still pending", $time, expected_verdicts.size());
      $display("gb18030_gbk_stream_validator_unit_tb: done, errors");
      $finish;
    end
  end

  function automatic bit is_digit(input logic [7:0] b);
    return b >= gbkv_pkg::DigitLo && b <= gbkv_pkg::DigitHi;
  endfunction

  function automatic void clear_string();
    seen_bytes  = '0;
    char_origin = '0;
    char_pos    = gbkv_pkg::PH_LEAD;
    char_lead   = 8'h00;
    halt_code   = gbkv_pkg::ST_OK;
  endfunction

  // Advance the shadow validator by one byte; returns 1 with the verdict on
  // the last byte of a string.
  function automatic bit track_gb_byte(input logic [7:0] b, input logic last,
                                       output gbkv_pkg::result_t verdict);
    verdict = '0;
    if (halt_code == gbkv_pkg::ST_OK) begin
      case (char_pos)
        gbkv_pkg::PH_LEAD: begin
          char_origin = seen_bytes;
          if (b < gbkv_pkg::HighLo) begin
            if (b == NulByte && nul_stop) halt_code = gbkv_pkg::ST_NUL;
          end else if (b == BadLead) begin
            halt_code = gbkv_pkg::ST_INVALID;
          end else begin
            char_lead = b;
            char_pos  = gbkv_pkg::PH_SECOND;
          end
        end
        gbkv_pkg::PH_SECOND: begin
          if (is_digit(b)) begin
            // only a lead of 0x81 and up opens a four-byte character
            if (char_lead >= gbkv_pkg::ExtLo) char_pos = gbkv_pkg::PH_THIRD;
            else halt_code = gbkv_pkg::ST_INVALID;
          end else if ((b >= gbkv_pkg::TrailLo && b <= gbkv_pkg::TrailHi) ||
                       (b >= gbkv_pkg::HighLo && b <= gbkv_pkg::HighHi)) begin
            char_pos = gbkv_pkg::PH_LEAD;
          end else begin
            halt_code = gbkv_pkg::ST_INVALID;
          end
        end
        gbkv_pkg::PH_THIRD: begin
          if (b >= gbkv_pkg::ExtLo && b <= gbkv_pkg::HighHi) char_pos = gbkv_pkg::PH_FOURTH;
          else halt_code = gbkv_pkg::ST_INVALID;
        end
        default: halt_code = is_digit(b) ? gbkv_pkg::ST_FOUR_BYTE : gbkv_pkg::ST_INVALID;
      endcase
    end
    // saturating byte counter
    if (seen_bytes != '1) seen_bytes = seen_bytes + 1'b1;
    if (!last) return 1'b0;
    // string ended inside a multi-byte character
    if (halt_code == gbkv_pkg::ST_OK && char_pos != gbkv_pkg::PH_LEAD) begin
      halt_code = gbkv_pkg::ST_INVALID;
    end
    verdict.length = (halt_code != gbkv_pkg::ST_OK) ? gbkv_pkg::LenW'(char_origin)
                                                     : gbkv_pkg::LenW'(seen_bytes);
    verdict.status = halt_code;
    clear_string();
    return 1'b1;
  endfunction

  // Offer one byte and hold it until taken; the shadow model runs at acceptance.
  task automatic push_byte(input logic [7:0] b, input logic last, input bit fixed,
                           input gbkv_pkg::result_t fixed_verdict);
    gbkv_pkg::result_t verdict;
    data_byte_i     <= b;
    end_of_string_i <= last;
    in_valid_i      <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
    if (track_gb_byte(b, last, verdict)) begin
      expected_verdicts.push_back(fixed ? fixed_verdict : verdict);
    end
  endtask

  // Sender bursts: a random gap now and then, sometimes none at all.
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
      burst_left = $urandom_range(24, 1);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
  endtask

  // Write stop_at_nul once nothing is in flight.
  task automatic set_nul_stop(input logic v);
    while (expected_verdicts.size() != 0) @(posedge clk_i);
    // trailing non-final bytes may still sit in the pipe
    repeat (SettleCyc) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    nul_stop    = v;
  endtask

  // Mostly well-formed GB18030 text; some NULs, broken four-byte
  // characters, loose noise bytes and truncated tails.
  function automatic void compose_string();
    int unsigned n_chars;
    int unsigned kind;
    int unsigned k;
    int unsigned cut;
    logic [7:0]  quad[4];
    string_bytes.delete();
    n_chars = ($urandom_range(19, 0) == 0) ? $urandom_range(40, 11) : $urandom_range(10, 1);
    for (int i = 0; i < n_chars; i++) begin
      kind = $urandom_range(99, 0);
      if (kind < 3) begin
        string_bytes.push_back(NulByte);
      end else if (kind < 40) begin
        string_bytes.push_back(8'($urandom_range(8'h7f, 1)));
      end else if (kind < 80) begin
        string_bytes.push_back(($urandom_range(15, 0) == 0) ? gbkv_pkg::HighLo
                               : 8'($urandom_range(gbkv_pkg::HighHi, gbkv_pkg::ExtLo)));
        string_bytes.push_back($urandom_range(1, 0)
                               ? 8'($urandom_range(gbkv_pkg::TrailHi, gbkv_pkg::TrailLo))
                               : 8'($urandom_range(gbkv_pkg::HighHi, gbkv_pkg::HighLo)));
      end else if (kind < 93) begin
        quad[0] = 8'($urandom_range(gbkv_pkg::HighHi, gbkv_pkg::ExtLo));
        quad[1] = 8'($urandom_range(gbkv_pkg::DigitHi, gbkv_pkg::DigitLo));
        quad[2] = 8'($urandom_range(gbkv_pkg::HighHi, gbkv_pkg::ExtLo));
        quad[3] = 8'($urandom_range(gbkv_pkg::DigitHi, gbkv_pkg::DigitLo));
        if (kind >= 88) begin
          k       = $urandom_range(3, 1);
          quad[k] = 8'($urandom_range(255, 0));
        end
        for (int j = 0; j < 4; j++) string_bytes.push_back(quad[j]);
      end else begin
        string_bytes.push_back(8'($urandom_range(255, 0)));
      end
    end
    // truncated tail: first one to three bytes of a four-byte character
    if ($urandom_range(9, 0) == 0) begin
      cut = $urandom_range(3, 1);
      string_bytes.push_back(8'($urandom_range(gbkv_pkg::HighHi, gbkv_pkg::ExtLo)));
      if (cut > 1) begin
        string_bytes.push_back(8'($urandom_range(gbkv_pkg::DigitHi, gbkv_pkg::DigitLo)));
      end
      if (cut > 2) begin
        string_bytes.push_back(8'($urandom_range(gbkv_pkg::HighHi, gbkv_pkg::ExtLo)));
      end
    end
  endfunction

  task automatic run_random(input int unsigned target);
    int unsigned sent;
    sent = 0;
    while (sent < target) begin
      compose_string();
      foreach (string_bytes[i]) begin
        pace_sender();
        push_byte(string_bytes[i], i == string_bytes.size() - 1, 1'b0, '0);
        sent++;
      end
    end
    in_valid_i <= 1'b0;
  endtask

  // Result checker: every taken word must match the oldest expected verdict.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_verdicts.size() == 0) begin
        $display("%0t: unexpected word, length %0d status %0d", $time,
                 accepted_length_o, status_o);
        error_count++;
      end else begin
        verdict_head = expected_verdicts.pop_front();
        verdicts_seen++;
        status_tally[status_o]++;
        if (accepted_length_o !== verdict_head.length) begin
          $display("%0t: length expected %0d, actual %0d", $time,
                   verdict_head.length, accepted_length_o);
          error_count++;
        end
        if (status_o !== verdict_head.status) begin
          $display("%0t: status expected %s, actual %0d", $time,
                   verdict_head.status.name(), status_o);
          error_count++;
        end
      end
    end
  end

  // Receiver: its own stall pattern, plus one long hold-off that backs the
  // block up until in_ready_o drops.
  initial begin : receiver
    int unsigned mode;
    int unsigned span;
    bit          held;
    held = 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end
      mode = $urandom_range(2, 0);
      span = $urandom_range(64, 8);
      repeat (span) begin
        case (mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= ($urandom_range(3, 0) != 0);
          default: out_ready_i <= ($urandom_range(2, 0) == 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    // directed strings, stop_at_nul at its reset value of 1
    dir_rows = '{
      '{8'h41, 1'b1, 1'b1, 24'd1, gbkv_pkg::ST_OK},        // lone ASCII
      '{8'h00, 1'b1, 1'b1, 24'd0, gbkv_pkg::ST_NUL},       // NUL lead
      '{8'hff, 1'b1, 1'b1, 24'd0, gbkv_pkg::ST_INVALID},   // 0xFF lead
      '{8'h80, 1'b0, 1'b0, 24'd0, gbkv_pkg::ST_OK},        // lead 0x80 two-byte
      '{8'h40, 1'b1, 1'b0, 24'd0, gbkv_pkg::ST_OK},
      '{8'h80, 1'b0, 1'b0, 24'd0, gbkv_pkg::ST_OK},        // lead 0x80 then digit
      '{8'h30, 1'b1, 1'b1, 24'd0, gbkv_pkg::ST_INVALID},
      '{8'hfe, 1'b0, 1'b0, 24'd0, gbkv_pkg::ST_OK},        // top two-byte
      '{8'hfe, 1'b1, 1'b0, 24'd0, gbkv_pkg::ST_OK},
      '{8'h81, 1'b0, 1'b0, 24'd0, gbkv_pkg::ST_OK},        // lowest four-byte
      '{8'h30, 1'b0, 1'b0, 24'd0, gbkv_pkg::ST_OK},
      '{8'h81, 1'b0, 1'b0, 24'd0, gbkv_pkg::ST_OK},
      '{8'h30, 1'b1, 1'b1, 24'd0, gbkv_pkg::ST_FOUR_BYTE},
      '{8'h7f, 1'b0, 1'b0, 24'd0, gbkv_pkg::ST_OK},        // highest four-byte after ASCII
      '{8'hfe, 1'b0, 1'b0, 24'd0, gbkv_pkg::ST_OK},
      '{8'h39, 1'b0, 1'b0, 24'd0, gbkv_pkg::ST_OK},
      '{8'hfe, 1'b0, 1'b0, 24'd0, gbkv_pkg::ST_OK},
      '{8'h39, 1'b1, 1'b0, 24'd0, gbkv_pkg::ST_OK},
      '{8'h41, 1'b0, 1'b0, 24'd0, gbkv_pkg::ST_OK},        // truncated two-byte
      '{8'h81, 1'b1, 1'b0, 24'd0, gbkv_pkg::ST_OK},
      '{8'h00, 1'b0, 1'b0, 24'd0, gbkv_pkg::ST_OK},        // bytes after a stop
      '{8'h41, 1'b1, 1'b1, 24'd0, gbkv_pkg::ST_NUL},
      '{8'h81, 1'b0, 1'b0, 24'd0, gbkv_pkg::ST_OK},        // bad trail byte
      '{8'h7f, 1'b1, 1'b0, 24'd0, gbkv_pkg::ST_OK}
    };
    nul_stop = 1'b1;
    clear_string();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < DirRows; r++) begin
      pace_sender();
      push_byte(dir_rows[r].data, dir_rows[r].last, dir_rows[r].fixed,
                '{length: dir_rows[r].len, status: dir_rows[r].st});
    end
    in_valid_i <= 1'b0;

    // random text under both NUL modes; long receiver hold in the first
    set_nul_stop(1'b0);
    hold_req = 1'b1;
    run_random(500);
    set_nul_stop(1'b1);
    run_random(500);
    set_nul_stop(1'b0);
    run_random(250);
    set_nul_stop(1'b1);
    run_random(250);

    while (expected_verdicts.size() != 0) @(posedge clk_i);
    repeat (DrainCyc) @(posedge clk_i);

    $display("Sent %0d bytes, checked %0d string verdicts in both NUL modes.",
             bytes_sent, verdicts_seen);
    $display("Verdicts: %0d valid, %0d invalid, %0d four-byte, %0d NUL stop.",
             status_tally[0], status_tally[1], status_tally[2], status_tally[3]);
    if (error_count == 0) begin
      $display("gb18030_gbk_stream_validator_unit_tb: done, clean");
    end else begin
      $display("gb18030_gbk_stream_validator_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
